// ===== rtl/core/ets_pkg.sv =====
// Shared types, constants and the control store for the epoch seconds to calendar block
package ets_pkg;

  // field widths
  localparam int unsigned UnixW   = 32;
  localparam int unsigned YearW   = 7;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned WdayW   = 3;
  localparam int unsigned DaysW   = 16;
  localparam int unsigned RemW    = 6;
  localparam int unsigned DivW    = RemW + 1;
  localparam int unsigned StepW   = 4;
  localparam int unsigned YlenW   = 9;
  localparam int unsigned RecipW  = 31;
  localparam int unsigned ProdW   = UnixW + RecipW;

  // calendar constants
  localparam logic [UnixW-1:0]  OffsetY2k    = 32'd946684800;
  localparam logic [DivW-1:0]   SecsPerMin   = 7'd60;
  localparam logic [DivW-1:0]   HoursPerDay  = 7'd24;
  localparam logic [DivW-1:0]   DaysPerWeek  = 7'd7;
  localparam logic [WdayW-1:0]  WdayEpoch    = 3'd6;
  localparam logic [YlenW-1:0]  DaysYear     = 9'd365;
  localparam logic [YlenW-1:0]  DaysLeapYear = 9'd366;
  localparam logic [YearW-1:0]  YearNoLeap   = 7'd100;
  localparam logic [MonthW-1:0] MonthJan     = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb     = 4'd2;
  localparam logic [MonthW-1:0] MonthApr     = 4'd4;
  localparam logic [MonthW-1:0] MonthJun     = 4'd6;
  localparam logic [MonthW-1:0] MonthSep     = 4'd9;
  localparam logic [MonthW-1:0] MonthNov     = 4'd11;
  localparam logic [MonthW-1:0] MonthDec     = 4'd12;

  // reciprocals for the quotient step, exact over the dividend range they see
  // divide by 60: (x >> 2) / 15, dividend below 2^30
  localparam logic [RecipW-1:0] Recip15  = 31'd1145324613;
  localparam int unsigned       Shift15  = 34;
  // divide by 24: (x >> 3) / 3, dividend below 2^29
  localparam logic [RecipW-1:0] Recip3   = 31'd715827883;
  localparam int unsigned       Shift3   = 31;
  // divide by 7: whole days, below 2^16
  localparam logic [RecipW-1:0] Recip7   = 31'd74899;
  localparam int unsigned       Shift7   = 19;

  // datapath operations
  typedef enum logic [3:0] {
    OP_WAIT,
    OP_DIV,
    OP_STORE_SEC,
    OP_STORE_MIN,
    OP_STORE_HR,
    OP_STORE_WD,
    OP_YEAR,
    OP_MONTH,
    OP_EMIT
  } op_e;

  // divisor select for the shared divide step
  typedef enum logic [1:0] {
    DIV_60,
    DIV_24,
    DIV_7
  } div_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_FIRE,
    COND_YEAR_DONE,
    COND_MONTH_DONE,
    COND_OUT_FREE
  } cond_e;

  typedef logic [StepW-1:0] step_t;

  // program step addresses
  localparam step_t StepWait    = 4'd0;
  localparam step_t StepDivSec  = 4'd1;
  localparam step_t StepSec     = 4'd2;
  localparam step_t StepDivMin  = 4'd3;
  localparam step_t StepMin     = 4'd4;
  localparam step_t StepDivHour = 4'd5;
  localparam step_t StepHour    = 4'd6;
  localparam step_t StepDivWday = 4'd7;
  localparam step_t StepWday    = 4'd8;
  localparam step_t StepYear    = 4'd9;
  localparam step_t StepMonth   = 4'd10;
  localparam step_t StepEmit    = 4'd11;
  localparam step_t StepLast    = StepEmit;

  // one control word: operation, divisor, jump condition and target
  typedef struct packed {
    op_e   op;
    div_e  dsel;
    cond_e cond;
    step_t target;
  } ucode_t;

  // datapath control from the sequencer
  typedef struct packed {
    op_e  op;
    div_e dsel;
    logic load;
  } dp_ctrl_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic year_done;
    logic month_done;
  } dp_stat_t;

  // one result item
  typedef struct packed {
    logic [YearW-1:0]  year_offset;
    logic [MonthW-1:0] month_number;
    logic [DayW-1:0]   day_of_month;
    logic [HourW-1:0]  hour_value;
    logic [MinW-1:0]   minute_value;
    logic [SecW-1:0]   second_value;
    logic [WdayW-1:0]  weekday;
    logic              in_range;
  } result_t;

  // control store: step on the condition, otherwise hold the step
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      StepWait:    w = '{OP_WAIT,      DIV_60, COND_IN_FIRE,    StepDivSec};
      StepDivSec:  w = '{OP_DIV,       DIV_60, COND_ALWAYS,     StepSec};
      StepSec:     w = '{OP_STORE_SEC, DIV_60, COND_ALWAYS,     StepDivMin};
      StepDivMin:  w = '{OP_DIV,       DIV_60, COND_ALWAYS,     StepMin};
      StepMin:     w = '{OP_STORE_MIN, DIV_60, COND_ALWAYS,     StepDivHour};
      StepDivHour: w = '{OP_DIV,       DIV_24, COND_ALWAYS,     StepHour};
      StepHour:    w = '{OP_STORE_HR,  DIV_24, COND_ALWAYS,     StepDivWday};
      StepDivWday: w = '{OP_DIV,       DIV_7,  COND_ALWAYS,     StepWday};
      StepWday:    w = '{OP_STORE_WD,  DIV_7,  COND_ALWAYS,     StepYear};
      StepYear:    w = '{OP_YEAR,      DIV_60, COND_YEAR_DONE,  StepMonth};
      StepMonth:   w = '{OP_MONTH,     DIV_60, COND_MONTH_DONE, StepEmit};
      StepEmit:    w = '{OP_EMIT,      DIV_60, COND_OUT_FREE,   StepWait};
      default:     w = '{OP_WAIT,      DIV_60, COND_ALWAYS,     StepWait};
    endcase
    return w;
  endfunction

  function automatic logic [DivW-1:0] div_value(input div_e sel);
    logic [DivW-1:0] v;
    case (sel)
      DIV_60:  v = SecsPerMin;
      DIV_24:  v = HoursPerDay;
      DIV_7:   v = DaysPerWeek;
      default: v = SecsPerMin;
    endcase
    return v;
  endfunction

  // days in a month, February lengthened in a leap year
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] mon, input logic leap);
    logic [DayW-1:0] len;
    case (mon) inside
      MonthFeb:                             len = leap ? 5'd29 : 5'd28;
      MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
      default:                              len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/ets_intf.sv =====
// Valid/ready channel interfaces for timestamps in and calendar results out
interface ets_in_if import ets_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [UnixW-1:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface ets_out_if import ets_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [YearW-1:0]  year_offset;
  logic [MonthW-1:0] month_number;
  logic [DayW-1:0]   day_of_month;
  logic [HourW-1:0]  hour_value;
  logic [MinW-1:0]   minute_value;
  logic [SecW-1:0]   second_value;
  logic [WdayW-1:0]  weekday;
  logic              in_range;

  modport source (output valid, output year_offset, output month_number, output day_of_month,
                  output hour_value, output minute_value, output second_value,
                  output weekday, output in_range, input ready);
  modport sink   (input valid, input year_offset, input month_number, input day_of_month,
                  input hour_value, input minute_value, input second_value,
                  input weekday, input in_range, output ready);
endinterface

// ===== rtl/core/ets_dp.sv =====
// Datapath: shared reciprocal divider, year and month walkers and field registers
module ets_dp import ets_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_ctrl_t         ctrl_i,
  input  logic [UnixW-1:0] unix_i,
  output dp_stat_t         stat_o,
  output result_t          res_o
);

  logic [UnixW-1:0]  num_q, num_d;
  logic [UnixW-1:0]  quot_q, quot_d;
  logic [SecW-1:0]   sec_q, sec_d;
  logic [MinW-1:0]   min_q, min_d;
  logic [HourW-1:0]  hr_q, hr_d;
  logic [WdayW-1:0]  wd_q, wd_d;
  logic [DaysW-1:0]  days_q, days_d;
  logic [YearW-1:0]  yoff_q, yoff_d;
  logic [MonthW-1:0] mon_q, mon_d;
  logic              range_q, range_d;

  logic [UnixW:0]    in_diff;
  logic              in_ge;
  logic [UnixW-1:0]  mul_a;
  logic [RecipW-1:0] mul_m;
  logic [ProdW-1:0]  prod;
  logic [UnixW-1:0]  quot;
  logic [DivW-1:0]   divisor;
  logic [UnixW-1:0]  back;
  logic [UnixW-1:0]  rem_full;
  logic [RemW-1:0]   rem;
  logic              leap;
  logic [YlenW-1:0]  year_len;
  logic [DayW-1:0]   mon_len;
  logic              year_done;
  logic              month_done;

  // epoch shift, borrow tells whether the input is before 2000
  assign in_diff = {1'b0, unix_i} - {1'b0, OffsetY2k};
  assign in_ge   = ~in_diff[UnixW];

  // quotient step: pre-shift and reciprocal for the selected divisor
  always_comb begin
    case (ctrl_i.dsel)
      DIV_24: begin
        mul_a = {3'b000, num_q[UnixW-1:3]};
        mul_m = Recip3;
      end
      DIV_7: begin
        mul_a = num_q;
        mul_m = Recip7;
      end
      default: begin
        mul_a = {2'b00, num_q[UnixW-1:2]};
        mul_m = Recip15;
      end
    endcase
  end

  assign prod = {{RecipW{1'b0}}, mul_a} * {{UnixW{1'b0}}, mul_m};

  always_comb begin
    case (ctrl_i.dsel)
      DIV_24:  quot = prod[Shift3 +: UnixW];
      DIV_7:   quot = prod[Shift7 +: UnixW];
      default: quot = {{(UnixW-(ProdW-Shift15)){1'b0}}, prod[ProdW-1:Shift15]};
    endcase
  end

  // remainder step: dividend less quotient times divisor
  assign divisor  = div_value(ctrl_i.dsel);
  assign back     = quot_q * {{(UnixW-DivW){1'b0}}, divisor};
  assign rem_full = num_q - back;
  assign rem      = rem_full[RemW-1:0];

  // leap rule over 2000..2106: every fourth year except 2100
  assign leap      = (yoff_q[1:0] == 2'd0) && (yoff_q != YearNoLeap);
  assign year_len  = leap ? DaysLeapYear : DaysYear;
  assign year_done = (days_q < {{(DaysW-YlenW){1'b0}}, year_len});
  assign mon_len   = month_len(mon_q, leap);
  assign month_done = (mon_q == MonthDec) || (days_q < {{(DaysW-DayW){1'b0}}, mon_len});

  // next-value logic per operation
  always_comb begin
    num_d   = num_q;
    quot_d  = quot_q;
    sec_d   = sec_q;
    min_d   = min_q;
    hr_d    = hr_q;
    wd_d    = wd_q;
    days_d  = days_q;
    yoff_d  = yoff_q;
    mon_d   = mon_q;
    range_d = range_q;
    case (ctrl_i.op)
      OP_WAIT: begin
        if (ctrl_i.load) begin
          range_d = in_ge;
          num_d   = in_ge ? in_diff[UnixW-1:0] : '0;
        end
      end
      OP_DIV: begin
        quot_d = quot;
      end
      OP_STORE_SEC: begin
        sec_d = rem;
        num_d = quot_q;
      end
      OP_STORE_MIN: begin
        min_d = rem;
        num_d = quot_q;
      end
      OP_STORE_HR: begin
        hr_d   = rem[HourW-1:0];
        days_d = quot_q[DaysW-1:0];
        num_d  = quot_q;
      end
      OP_STORE_WD: begin
        // (r + 6) mod 7 for r in 0..6
        wd_d   = (rem[WdayW-1:0] == 3'd0) ? WdayEpoch : (rem[WdayW-1:0] - 3'd1);
        yoff_d = '0;
        mon_d  = MonthJan;
      end
      OP_YEAR: begin
        if (!year_done) begin
          days_d = days_q - {{(DaysW-YlenW){1'b0}}, year_len};
          yoff_d = yoff_q + 1'b1;
        end
      end
      OP_MONTH: begin
        if (!month_done) begin
          days_d = days_q - {{(DaysW-DayW){1'b0}}, mon_len};
          mon_d  = mon_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // working and field registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q   <= '0;
      quot_q  <= '0;
      sec_q   <= '0;
      min_q   <= '0;
      hr_q    <= '0;
      wd_q    <= WdayEpoch;
      days_q  <= '0;
      yoff_q  <= '0;
      mon_q   <= MonthJan;
      range_q <= 1'b0;
    end else begin
      num_q   <= num_d;
      quot_q  <= quot_d;
      sec_q   <= sec_d;
      min_q   <= min_d;
      hr_q    <= hr_d;
      wd_q    <= wd_d;
      days_q  <= days_d;
      yoff_q  <= yoff_d;
      mon_q   <= mon_d;
      range_q <= range_d;
    end
  end

  // status and assembled result
  assign stat_o.year_done  = year_done;
  assign stat_o.month_done = month_done;

  assign res_o.year_offset  = yoff_q;
  assign res_o.month_number = mon_q;
  assign res_o.day_of_month = days_q[DayW-1:0] + 1'b1;
  assign res_o.hour_value   = hr_q;
  assign res_o.minute_value = min_q;
  assign res_o.second_value = sec_q;
  assign res_o.weekday      = wd_q;
  assign res_o.in_range     = range_q;

endmodule

// ===== rtl/core/epoch_seconds_to_calendar.sv =====
// Top level: microcoded converter from Unix seconds to calendar date, time and weekday
//
// Takes one Unix timestamp per transfer and gives one result: years since 2000, month,
// day, hour, minute, second, weekday (0 = Sunday) and an in_range flag. Inputs before
// 2000-01-01 give 2000-01-01 00:00:00, weekday 6, in_range 0. A twelve-step program
// in a control store drives one shared divider by a constant: each of the divisions by
// 60, 60, 24 and 7 takes a quotient step (multiply by a fixed reciprocal and shift) and
// a remainder step, and then walks whole days one year and one month per cycle. The
// last step waits while the output register still holds a result that has not been
// taken. The input is ready again the cycle after the result is loaded into the output
// register, so the next timestamp can be taken while a result still waits there.
module epoch_seconds_to_calendar import ets_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ets_in_if.sink    in_i,
  ets_out_if.source out_o
);

  step_t    pc_q, pc_d;
  ucode_t   uword;
  dp_ctrl_t dp_ctrl;
  dp_stat_t dp_stat;
  result_t  dp_res;
  result_t  out_q;
  logic     out_valid_q, out_valid_d;
  logic     in_fire;
  logic     out_free;
  logic     cond_ok;

  // control word of the current step
  assign uword = ucode_rom(pc_q);

  assign in_i.ready = (uword.op == OP_WAIT);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign dp_ctrl.op   = uword.op;
  assign dp_ctrl.dsel = uword.dsel;
  assign dp_ctrl.load = in_fire;

  ets_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dp_ctrl),
    .unix_i (in_i.unix_seconds),
    .stat_o (dp_stat),
    .res_o  (dp_res)
  );

  // jump condition select
  always_comb begin
    case (uword.cond)
      COND_ALWAYS:     cond_ok = 1'b1;
      COND_IN_FIRE:    cond_ok = in_fire;
      COND_YEAR_DONE:  cond_ok = dp_stat.year_done;
      COND_MONTH_DONE: cond_ok = dp_stat.month_done;
      COND_OUT_FREE:   cond_ok = out_free;
      default:         cond_ok = 1'b1;
    endcase
  end

  // step counter
  assign pc_d = cond_ok ? uword.target : pc_q;

  // output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (uword.op == OP_EMIT && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= StepWait;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (uword.op == OP_EMIT && out_free) begin
      out_q <= dp_res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.year_offset  = out_q.year_offset;
  assign out_o.month_number = out_q.month_number;
  assign out_o.day_of_month = out_q.day_of_month;
  assign out_o.hour_value   = out_q.hour_value;
  assign out_o.minute_value = out_q.minute_value;
  assign out_o.second_value = out_q.second_value;
  assign out_o.weekday      = out_q.weekday;
  assign out_o.in_range     = out_q.in_range;

  // checks on the sequencer and the result
  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= StepLast)
    else $error("step counter left the program");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uword.op == OP_EMIT && out_free) |=> out_o.valid)
    else $error("result not presented after emit");

  a_early_epoch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uword.op == OP_EMIT && !dp_res.in_range) |->
      (dp_res.year_offset == '0 && dp_res.month_number == MonthJan &&
       dp_res.day_of_month == 5'd1 && dp_res.hour_value == '0 &&
       dp_res.weekday == WdayEpoch))
    else $error("input before 2000 did not give the epoch");

  a_fields_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uword.op == OP_EMIT) |->
      (dp_res.month_number >= MonthJan && dp_res.month_number <= MonthDec &&
       dp_res.day_of_month != '0 && dp_res.hour_value < 5'd24 &&
       dp_res.weekday < 3'd7))
    else $error("calendar field out of range at emit");

endmodule
